// ----- rtl/ialu_pkg.sv -----
`default_nettype none
package ialu_pkg;

  // Operation codes.
  typedef enum logic [5:0] {
    OP_OR = 6'd0, OP_AND = 6'd1, OP_XOR = 6'd2, OP_NOT = 6'd3, OP_LSH = 6'd4,
    OP_RASH = 6'd5, OP_RLSH = 6'd6, OP_ADD = 6'd7, OP_SUB = 6'd8, OP_MUL = 6'd9,
    OP_DIV = 6'd10, OP_NEG = 6'd11, OP_ADDC = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14,
    OP_UADD = 6'd15, OP_USUB = 6'd16, OP_UMUL = 6'd17, OP_UDIV = 6'd18,
    OP_CMP = 6'd19, OP_CMPU = 6'd20, OP_CMPL = 6'd21, OP_SGN = 6'd22,
    OP_EQ = 6'd23, OP_NE = 6'd24, OP_GT = 6'd25, OP_GE = 6'd26, OP_LT = 6'd27,
    OP_LE = 6'd28, OP_CS = 6'd29, OP_CC = 6'd30, OP_ZS = 6'd31, OP_ZC = 6'd32,
    OP_NAN = 6'd33, OP_AN = 6'd34, OP_AB = 6'd35, OP_SB = 6'd36, OP_NB = 6'd37
  } op_t;

  // Status flag bit positions.
  localparam int F_ZERO = 0;
  localparam int F_OVER = 1;
  localparam int F_EQ   = 2;
  localparam int F_GT   = 3;
  localparam int F_LT   = 4;
  localparam int F_NONE = 5;
  localparam int F_SOME = 6;
  localparam int F_ALL  = 7;
  localparam int F_NAN  = 8;
  localparam int FlagW  = 9;

  typedef logic [FlagW-1:0] flags_t;

endpackage
`default_nettype wire

// ----- rtl/ialu_if.sv -----
`default_nettype none
interface ialu_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  func;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface ialu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_main;
  logic [63:0] result_second;
  logic        writes_main;
  logic        writes_second;
  logic        branch_taken;
  logic        arith_error;
  logic [8:0]  flags_out;
  modport source (output valid, result_main, result_second, writes_main, writes_second,
                  branch_taken, arith_error, flags_out, input ready);
  modport sink (input valid, result_main, result_second, writes_main, writes_second,
                branch_taken, arith_error, flags_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/ialu_div.sv -----
`default_nettype none
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module ialu_div #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] dvs;
  logic [CW-1:0] count;
  logic busy;
  logic [W:0] trial;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quot[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(W);
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial[W]) begin
        rem <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end else begin
        rem <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/integer_alu_with_status_flags.sv -----
`default_nettype none
// Logic, add, shift, compare, test and divide-by-zero requests finish in the execute state;
// divides wait in the divide state for the divider. Multiplies run a shift-and-add loop
// that stops once no multiplier bits remain.
// One request at a time; the bit-per-cycle divide and multiply loops set
// their cost. A finished result waits in the output register until taken; the next
// request is accepted in the same cycle the result leaves.
// Reset (rst, synchronous) clears the status flags and the sequencer.
module integer_alu_with_status_flags #(
  parameter int DATA_WIDTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  ialu_in_if.sink  in_ch,
  ialu_out_if.source out_ch
);
  import ialu_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int SW = $clog2(W);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_MUL, S_OUT} state_t;

  state_t state;
  op_t op;
  logic [W-1:0] a, b;
  flags_t st;

  // Shift-and-add multiplier registers.
  logic [W-1:0] prod, mcand, mplier;

  // Divider hookup.
  logic div_start, div_done;
  logic [W-1:0] div_q, div_r, mag_a, mag_b;
  logic a_neg, b_neg, is_sdiv;

  assign a_neg = a[W-1];
  assign b_neg = b[W-1];
  assign is_sdiv = (op == OP_DIV);
  assign mag_a = (is_sdiv && a_neg) ? -a : a;
  assign mag_b = (is_sdiv && b_neg) ? -b : b;

  ialu_div #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mag_a), .divisor(mag_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // Combinational operation logic.
  logic [SW-1:0] s;
  logic [W-1:0] r, sum, dif, sar_r, t;
  logic wm, taken;
  flags_t st_n;
  logic gt_s, lt_s;

  assign s = b[SW-1:0];
  assign sum = a + b;
  assign dif = a - b;
  assign sar_r = W'($signed(a) >>> s);
  assign gt_s = $signed(a) > $signed(b);
  assign lt_s = $signed(a) < $signed(b);
  assign t = a & b;

  function automatic flags_t order(flags_t f, logic gt, logic lt);
    flags_t o;
    o = f;
    o[F_EQ] = !gt && !lt;
    o[F_GT] = gt;
    o[F_LT] = !gt && lt;
    return o;
  endfunction

  always_comb begin
    r = '0;
    wm = 1'b0;
    taken = 1'b0;
    st_n = st;
    unique case (op)
      OP_OR:  begin r = a | b; wm = 1'b1; st_n[F_ZERO] = (r == '0); end
      OP_AND: begin r = t; wm = 1'b1; st_n[F_ZERO] = (r == '0); end
      OP_XOR: begin r = a ^ b; wm = 1'b1; st_n[F_ZERO] = (r == '0); end
      OP_NOT: begin r = ~a; wm = 1'b1; st_n[F_ZERO] = (r == '0); end
      OP_LSH: begin
        r = a << s; wm = 1'b1;
        st_n[F_OVER] = (W'($signed(r) >>> s) != a);
      end
      OP_RASH: begin r = sar_r; wm = 1'b1; st_n[F_OVER] = ((r << s) != a); end
      OP_RLSH: begin r = a >> s; wm = 1'b1; st_n[F_OVER] = ((r << s) != a); end
      OP_ADD: begin
        r = sum; wm = 1'b1;
        st_n[F_OVER] = (a_neg == b_neg) && (r[W-1] != a_neg);
        st_n[F_ZERO] = (r == '0);
      end
      OP_SUB: begin
        r = dif; wm = 1'b1;
        st_n[F_OVER] = (a_neg != b_neg) && (r[W-1] != a_neg);
        st_n[F_ZERO] = (r == '0);
      end
      OP_MUL: begin r = prod; wm = 1'b1; st_n[F_ZERO] = (r == '0); end
      OP_NEG: begin
        r = -a; wm = 1'b1;
        st_n[F_OVER] = (a == {1'b1, {(W-1){1'b0}}});
      end
      OP_ADDC: begin
        r = sum + W'(st[F_OVER]); wm = 1'b1;
        st_n[F_OVER] = (a_neg == b_neg) && (r[W-1] != a_neg);
      end
      OP_INC: begin
        r = a + 1'b1; wm = 1'b1;
        st_n[F_OVER] = (a == {1'b0, {(W-1){1'b1}}});
        st_n[F_ZERO] = (a == '1);
      end
      OP_DEC: begin
        r = a - 1'b1; wm = 1'b1;
        st_n[F_OVER] = (a == {1'b1, {(W-1){1'b0}}});
        st_n[F_ZERO] = (a == W'(1));
      end
      OP_UADD: begin r = sum; wm = 1'b1; end
      OP_USUB: begin r = dif; wm = 1'b1; end
      OP_UMUL: begin r = prod; wm = 1'b1; end
      OP_CMP:  st_n = order(st, gt_s, lt_s);
      OP_CMPU: st_n = order(st, a > b, a < b);
      OP_CMPL: begin
        st_n[F_NONE] = (t == '0);
        st_n[F_SOME] = (t != '0);
        st_n[F_ALL]  = (t != '0) && (t == b);
      end
      OP_SGN: st_n = order(st, !a_neg && (a != '0), a_neg);
      OP_EQ:  taken = st[F_EQ];
      OP_NE:  taken = !st[F_EQ];
      OP_GT:  taken = st[F_GT];
      OP_GE:  taken = st[F_EQ] || st[F_GT];
      OP_LT:  taken = st[F_LT];
      OP_LE:  taken = st[F_EQ] || st[F_LT];
      OP_CS:  taken = st[F_OVER];
      OP_CC:  taken = !st[F_OVER];
      OP_ZS:  taken = st[F_ZERO];
      OP_ZC:  taken = !st[F_ZERO];
      OP_NAN: taken = st[F_NAN];
      OP_AN:  taken = !st[F_NAN];
      OP_AB:  taken = st[F_ALL];
      OP_SB:  taken = st[F_SOME];
      OP_NB:  taken = st[F_NONE];
      default: ;
    endcase
  end

  // Signed fix-up of the divider's magnitudes.
  logic [W-1:0] dq, dr;
  assign dq = (is_sdiv && (a_neg != b_neg)) ? -div_q : div_q;
  assign dr = (is_sdiv && a_neg) ? -div_r : div_r;

  assign in_ch.ready = (state == S_IDLE) || (state == S_OUT && out_ch.ready);
  assign out_ch.valid = (state == S_OUT);
  assign div_start = (state == S_EXEC) && (op == OP_DIV || op == OP_UDIV) && (b != '0);

  // Sequencer, operand registers, flags and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st <= '0;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: begin
          if (in_ch.valid && in_ch.ready) begin
            op <= op_t'(in_ch.func);
            a <= in_ch.operand_a[W-1:0];
            b <= in_ch.operand_b[W-1:0];
            state <= S_EXEC;
          end else if (state == S_OUT && out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          out_ch.result_second <= '0;
          out_ch.writes_second <= 1'b0;
          out_ch.arith_error <= 1'b0;
          out_ch.branch_taken <= 1'b0;
          if (op == OP_DIV || op == OP_UDIV) begin
            if (b == '0) begin
              out_ch.result_main <= '0;
              out_ch.writes_main <= 1'b0;
              out_ch.arith_error <= 1'b1;
              out_ch.flags_out <= st;
              state <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end else if (op == OP_MUL || op == OP_UMUL) begin
            // Start the shift-and-add loop from a cleared product.
            prod <= '0;
            mcand <= a;
            mplier <= b;
            state <= S_MUL;
          end else begin
            out_ch.result_main <= 64'($signed(r));
            out_ch.writes_main <= wm;
            out_ch.branch_taken <= taken;
            out_ch.flags_out <= st_n;
            st <= st_n;
            state <= S_OUT;
          end
        end
        S_MUL: begin
          // One multiplier bit per cycle until no set bits remain.
          if (mplier == '0) begin
            out_ch.result_main <= 64'($signed(r));
            out_ch.writes_main <= 1'b1;
            out_ch.flags_out <= st_n;
            st <= st_n;
            state <= S_OUT;
          end else begin
            if (mplier[0]) prod <= prod + mcand;
            mcand <= {mcand[W-2:0], 1'b0};
            mplier <= {1'b0, mplier[W-1:1]};
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_ch.result_main <= 64'($signed(dq));
            out_ch.result_second <= 64'($signed(dr));
            out_ch.writes_main <= 1'b1;
            out_ch.writes_second <= 1'b1;
            out_ch.flags_out <= st;
            state <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/integer_alu_with_status_flags_chk.sv -----
`timescale 1ns / 100ps
module integer_alu_with_status_flags_chk (
  input wire logic clk,
  input wire logic rst,
  ialu_in_if.sink  req_mon,
  ialu_out_if.sink rsp_mon,
  output int       fail_count,
  output int       pending
);
  import ialu_pkg::*;

  typedef struct packed {
    logic [63:0] main;
    logic [63:0] second;
    logic        wm;
    logic        ws;
    logic        taken;
    logic        err;
    flags_t      flags;
  } alu_result_t;

  alu_result_t expected_results[$];
  flags_t      status;

  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  // Signed greater-than on raw bit vectors.
  function automatic logic sgt(input logic [63:0] x, input logic [63:0] y);
    return (x ^ SIGN) > (y ^ SIGN);
  endfunction

  function automatic flags_t order(input flags_t st, input logic gt, input logic lt);
    st[F_EQ] = !gt && !lt;
    st[F_GT] = gt;
    st[F_LT] = !gt && lt;
    return st;
  endfunction

  // Works out the result of one request and advances the status flags.
  function automatic alu_result_t execute_op(input logic [5:0] func, input logic [63:0] a,
                                             input logic [63:0] b);
    alu_result_t res;
    logic [63:0] r, r2, ma, mb;
    flags_t      st;
    int          s;
    res = '0;
    r = '0;
    r2 = '0;
    st = status;
    s = b[5:0];
    case (func)
      OP_OR: begin r = a | b; res.wm = 1; st[F_ZERO] = r == 0; end
      OP_AND: begin r = a & b; res.wm = 1; st[F_ZERO] = r == 0; end
      OP_XOR: begin r = a ^ b; res.wm = 1; st[F_ZERO] = r == 0; end
      OP_NOT: begin r = ~a; res.wm = 1; st[F_ZERO] = r == 0; end
      OP_LSH: begin
        r = a << s; res.wm = 1; st[F_OVER] = 64'($signed(r) >>> s) != a;
      end
      OP_RASH: begin
        r = $signed(a) >>> s; res.wm = 1; st[F_OVER] = (r << s) != a;
      end
      OP_RLSH: begin r = a >> s; res.wm = 1; st[F_OVER] = (r << s) != a; end
      OP_ADD: begin
        r = a + b; res.wm = 1;
        st[F_OVER] = a[63] == b[63] && r[63] != a[63]; st[F_ZERO] = r == 0;
      end
      OP_SUB: begin
        r = a - b; res.wm = 1;
        st[F_OVER] = a[63] != b[63] && r[63] != a[63]; st[F_ZERO] = r == 0;
      end
      OP_MUL: begin r = a * b; res.wm = 1; st[F_ZERO] = r == 0; end
      OP_DIV: begin
        if (b == 0) begin
          res.err = 1;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          r = ma / mb;
          r2 = ma % mb;
          if (a[63] != b[63]) r = -r;
          if (a[63]) r2 = -r2;
          res.wm = 1; res.ws = 1;
        end
      end
      OP_NEG: begin r = -a; res.wm = 1; st[F_OVER] = a == SIGN; end
      OP_ADDC: begin
        r = a + b + {63'b0, st[F_OVER]}; res.wm = 1;
        st[F_OVER] = a[63] == b[63] && r[63] != a[63];
      end
      OP_INC: begin
        r = a + 1; res.wm = 1; st[F_OVER] = a == ~SIGN; st[F_ZERO] = a == '1;
      end
      OP_DEC: begin
        r = a - 1; res.wm = 1; st[F_OVER] = a == SIGN; st[F_ZERO] = a == 1;
      end
      OP_UADD: begin r = a + b; res.wm = 1; end
      OP_USUB: begin r = a - b; res.wm = 1; end
      OP_UMUL: begin r = a * b; res.wm = 1; end
      OP_UDIV: begin
        if (b == 0) res.err = 1;
        else begin r = a / b; r2 = a % b; res.wm = 1; res.ws = 1; end
      end
      OP_CMP: st = order(st, sgt(a, b), sgt(b, a));
      OP_CMPU: st = order(st, a > b, a < b);
      OP_CMPL: begin
        st[F_NONE] = (a & b) == 0;
        st[F_SOME] = (a & b) != 0;
        st[F_ALL] = (a & b) != 0 && (a & b) == b;
      end
      OP_SGN: st = order(st, sgt(a, 0), a[63]);
      OP_EQ: res.taken = st[F_EQ];
      OP_NE: res.taken = !st[F_EQ];
      OP_GT: res.taken = st[F_GT];
      OP_GE: res.taken = st[F_EQ] | st[F_GT];
      OP_LT: res.taken = st[F_LT];
      OP_LE: res.taken = st[F_EQ] | st[F_LT];
      OP_CS: res.taken = st[F_OVER];
      OP_CC: res.taken = !st[F_OVER];
      OP_ZS: res.taken = st[F_ZERO];
      OP_ZC: res.taken = !st[F_ZERO];
      OP_NAN: res.taken = st[F_NAN];
      OP_AN: res.taken = !st[F_NAN];
      OP_AB: res.taken = st[F_ALL];
      OP_SB: res.taken = st[F_SOME];
      OP_NB: res.taken = st[F_NONE];
      default: ;
    endcase
    status = st;
    res.main = res.wm ? r : '0;
    res.second = res.ws ? r2 : '0;
    res.flags = st;
    return res;
  endfunction

  assign pending = expected_results.size();

  // Predict on each accepted request and compare each accepted result.
  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      status = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(execute_op(req_mon.func, req_mon.operand_a,
                                              req_mon.operand_b));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (rsp_mon.result_main !== want.main ||
              rsp_mon.result_second !== want.second ||
              rsp_mon.writes_main !== want.wm || rsp_mon.writes_second !== want.ws ||
              rsp_mon.branch_taken !== want.taken || rsp_mon.arith_error !== want.err ||
              rsp_mon.flags_out !== want.flags) begin
            fail_count <= fail_count + 1;
            if (rsp_mon.result_main !== want.main)
              $error("result_main expected %h actual %h", want.main, rsp_mon.result_main);
            if (rsp_mon.result_second !== want.second)
              $error("result_second expected %h actual %h", want.second,
                     rsp_mon.result_second);
            if (rsp_mon.writes_main !== want.wm)
              $error("writes_main expected %b actual %b", want.wm, rsp_mon.writes_main);
            if (rsp_mon.writes_second !== want.ws)
              $error("writes_second expected %b actual %b", want.ws, rsp_mon.writes_second);
            if (rsp_mon.branch_taken !== want.taken)
              $error("branch_taken expected %b actual %b", want.taken, rsp_mon.branch_taken);
            if (rsp_mon.arith_error !== want.err)
              $error("arith_error expected %b actual %b", want.err, rsp_mon.arith_error);
            if (rsp_mon.flags_out !== want.flags)
              $error("flags_out expected %h actual %h", want.flags, rsp_mon.flags_out);
          end
        end
      end
    end
  end

endmodule

// ----- tb/integer_alu_with_status_flags_tb.sv -----
`timescale 1ns / 100ps
module integer_alu_with_status_flags_tb;
  import ialu_pkg::*;

  localparam int LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 0;
  int   quiet = 0;

  ialu_in_if  req_ch();
  ialu_out_if rsp_ch();

  integer_alu_with_status_flags uut (.clk(clk), .rst(rst), .in_ch(req_ch), .out_ch(rsp_ch));
  integer_alu_with_status_flags_chk chk (.clk(clk), .rst(rst), .req_mon(req_ch),
                                         .rsp_mon(rsp_ch), .fail_count(fail_count),
                                         .pending(pending));

  always #10 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.func = '0;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    rsp_ch.ready = 0;
  end

  // Receiver: random stalls, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) rsp_ch.ready <= 0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles without any accepted handshake.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst || hold_off)
      quiet <= 0;
    else if (quiet >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else quiet <= quiet + 1;
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return 64'($urandom_range(3));
      4: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one request and wait for it to be taken; valid drops only while idling.
  task automatic send_req(input logic [5:0] f, input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 0;
      @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.func <= f;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_run(input int n);
    logic [5:0] f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 38)) : 6'($urandom_range(37));
      send_req(f, pick_operand(), ($urandom_range(9) == 0) ? 64'h0 : pick_operand());
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed: extremes, divide by zero, overflowing divide, shifts, tests.
    send_req(OP_DIV, 64'h8000_0000_0000_0000, '1);
    send_req(OP_DIV, 64'd7, 64'd0);
    send_req(OP_UDIV, '1, 64'd0);
    send_req(OP_DIV, -64'sd7, 64'd2);
    send_req(OP_UDIV, '1, 64'd3);
    send_req(OP_LSH, 64'h1, 64'd65);
    send_req(OP_RASH, 64'h8000_0000_0000_0001, 64'd63);
    send_req(OP_RLSH, '1, 64'd64);
    send_req(OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
    send_req(OP_ADDC, 64'd1, 64'd1);
    send_req(OP_SUB, 64'h8000_0000_0000_0000, 64'd1);
    send_req(OP_NEG, 64'h8000_0000_0000_0000, '0);
    send_req(OP_INC, '1, '0);
    send_req(OP_DEC, 64'd1, '0);
    send_req(OP_CMP, '1, 64'd1);
    send_req(OP_CMPU, '1, 64'd1);
    send_req(OP_CMPL, 64'hff, 64'h0f);
    send_req(OP_SGN, '0, '0);
    send_req(6'd63, '1, '1);
    for (int f = OP_EQ; f <= OP_NB; f++) send_req(6'(f), '0, '0);
    // Random phases with different idling.
    send_idle = 26; recv_idle = 76;
    random_run(450);
    send_idle = 76; recv_idle = 26;
    random_run(450);
    send_idle = 0; recv_idle = 0;
    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      random_run(20);
    join
    random_run(610);
    req_ch.valid <= 0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- integer_alu_with_status_flags.f -----
rtl/ialu_pkg.sv
rtl/ialu_if.sv
rtl/ialu_div.sv
rtl/integer_alu_with_status_flags.sv
tb/integer_alu_with_status_flags_chk.sv
tb/integer_alu_with_status_flags_tb.sv
